### rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper with timer irq.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // field widths
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CYC_W      = 10;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CYCLE_BITS = 10;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 9;

  // only the low CYCLE_BITS bits of a tick's cycle count are used
  localparam logic [CYC_W-1:0] CYC_MASK = CYC_W'((17'd1 << CYCLE_BITS) - 17'd1);

  // address decode
  localparam logic [ADDR_W-1:0] DEC_MASK   = 16'hE000;
  localparam logic [ADDR_W-1:0] DEC_CMD    = 16'h8000;
  localparam logic [ADDR_W-1:0] DEC_PARAM  = 16'hA000;
  localparam logic [CNT_W-1:0]  CNT_RELOAD = 16'hFFFF;
  localparam int unsigned       PRG_LOCK_BIT = 6;

  // request kinds
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_t;

  // commands latched at the command address
  typedef enum logic [3:0] {
    CMD_CHR0  = 4'd0,
    CMD_CHR1  = 4'd1,
    CMD_CHR2  = 4'd2,
    CMD_CHR3  = 4'd3,
    CMD_CHR4  = 4'd4,
    CMD_CHR5  = 4'd5,
    CMD_CHR6  = 4'd6,
    CMD_CHR7  = 4'd7,
    CMD_PRG3  = 4'd8,
    CMD_PRG4  = 4'd9,
    CMD_PRG5  = 4'd10,
    CMD_PRG6  = 4'd11,
    CMD_MIRR  = 4'd12,
    CMD_IRQEN = 4'd13,
    CMD_CNTLO = 4'd14,
    CMD_CNTHI = 4'd15
  } cmd_t;

  // bank change event codes
  typedef enum logic [1:0] {
    BW_NONE = 2'd0,
    BW_PRG  = 2'd1,
    BW_CHR  = 2'd2
  } bank_write_t;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PRG_SIZE    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHR_PRESENT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PATCH_MODE  = 2'd2;

  typedef struct packed {
    logic [CYC_W-1:0]  cycles;
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] address;
    req_type_t         req_type;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] bank_value;
    logic [2:0]        bank_slot;
    bank_write_t       bank_write;
    logic [1:0]        mirroring;
    logic              irq_out;
  } out_item_t;

endpackage

### rtl/cartridge_bank_mapper_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq
// Command/parameter register decode and down-counting timer irq of a
// cartridge bank mapper; reports each bank change as an event.
// ----------------------------------------------------------------------------
// Each request (a CPU write or a timer tick) gives exactly one result. A
// request is taken into an input register, then decoded against the command
// latch and the irq counter and written to the result register. A new
// request is accepted every cycle as long as results are taken. Besides
// the bank slot offset, the only arithmetic is one 16-bit subtract and
// compare of the counter. Bank numbers are not stored: every bank change
// is reported on the result channel with its slot and value, and the size
// and character-rom registers are not stored by this block.
module cartridge_bank_mapper_irq (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cbm_pkg::IN_TDATA_W-1:0]      in_tdata,   // address, data, cycles, zero pad
  input  logic                                in_tuser,   // req_type
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cbm_pkg::OUT_TDATA_W-1:0]     out_tdata,  // irq_out, mirroring, bank_write,
                                                          // bank_slot, bank_value
  // configuration
  input  logic                                cfg_we,
  input  logic [cbm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned ITEM_W = $bits(cbm_pkg::in_item_t) - 1;

  // configuration
  logic patch_mode_r;

  // pipeline
  logic               in_valid_r;
  cbm_pkg::in_item_t  in_item_r;
  logic               out_valid_r;
  cbm_pkg::out_item_t out_item_r;
  logic               advance;

  // mapper state
  logic [3:0]                  cmd_r;
  logic                        irq_en_r;
  logic [cbm_pkg::CNT_W-1:0]   cnt_r;
  logic                        irq_r;
  logic [1:0]                  mirr_r;

  logic [3:0]                  cmd_nxt;
  logic                        irq_en_nxt;
  logic [cbm_pkg::CNT_W-1:0]   cnt_nxt;
  logic                        irq_nxt;
  logic [1:0]                  mirr_nxt;
  cbm_pkg::out_item_t          res_nxt;

  logic [cbm_pkg::ADDR_W-1:0]  dec;
  logic [cbm_pkg::CYC_W-1:0]   cyc;
  logic                        fire;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_mode_r <= 1'b0;
    end else if (cfg_we && cfg_addr == cbm_pkg::CFG_PATCH_MODE) begin
      patch_mode_r <= cfg_wdata[0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= {in_tdata[ITEM_W-1:0], in_tuser};
    end
  end

  // decode and counter update
  always_comb begin
    dec  = in_item_r.address & cbm_pkg::DEC_MASK;
    cyc  = in_item_r.cycles & cbm_pkg::CYC_MASK;
    // count minus cycles at or below zero
    fire = {1'b0, cnt_r} <= {{(cbm_pkg::CNT_W + 1 - cbm_pkg::CYC_W){1'b0}}, cyc};

    cmd_nxt    = cmd_r;
    irq_en_nxt = irq_en_r;
    cnt_nxt    = cnt_r;
    irq_nxt    = irq_r;
    mirr_nxt   = mirr_r;

    res_nxt.bank_write = cbm_pkg::BW_NONE;
    res_nxt.bank_slot  = 3'd0;
    res_nxt.bank_value = '0;

    if (in_item_r.req_type == cbm_pkg::REQ_TICK) begin
      if (irq_en_r) begin
        if (fire) begin
          irq_nxt    = 1'b1;
          irq_en_nxt = 1'b0;
          cnt_nxt    = cbm_pkg::CNT_RELOAD;
        end else begin
          cnt_nxt = cnt_r - {{(cbm_pkg::CNT_W - cbm_pkg::CYC_W){1'b0}}, cyc};
        end
      end
    end else if (dec == cbm_pkg::DEC_CMD) begin
      cmd_nxt = in_item_r.data[3:0];
    end else if (dec == cbm_pkg::DEC_PARAM) begin
      case (cbm_pkg::cmd_t'(cmd_r)) inside
        [cbm_pkg::CMD_CHR0:cbm_pkg::CMD_CHR7]: begin
          res_nxt.bank_write = cbm_pkg::BW_CHR;
          res_nxt.bank_slot  = cmd_r[2:0];
          res_nxt.bank_value = in_item_r.data;
        end
        cbm_pkg::CMD_PRG3: begin
          // blocked in patch mode or with the lock bit set
          if (!patch_mode_r && !in_item_r.data[cbm_pkg::PRG_LOCK_BIT]) begin
            res_nxt.bank_write = cbm_pkg::BW_PRG;
            res_nxt.bank_slot  = 3'd3;
            res_nxt.bank_value = in_item_r.data;
          end
        end
        [cbm_pkg::CMD_PRG4:cbm_pkg::CMD_PRG6]: begin
          res_nxt.bank_write = cbm_pkg::BW_PRG;
          res_nxt.bank_slot  = 3'(cmd_r - 4'd5);
          res_nxt.bank_value = in_item_r.data;
        end
        cbm_pkg::CMD_MIRR: begin
          mirr_nxt = in_item_r.data[1:0];
        end
        cbm_pkg::CMD_IRQEN: begin
          irq_en_nxt = |in_item_r.data;
          irq_nxt    = 1'b0;
        end
        cbm_pkg::CMD_CNTLO: begin
          cnt_nxt = {cnt_r[15:8], in_item_r.data};
          irq_nxt = 1'b0;
        end
        cbm_pkg::CMD_CNTHI: begin
          cnt_nxt = {in_item_r.data, cnt_r[7:0]};
          irq_nxt = 1'b0;
        end
        default: begin
          cmd_nxt = cmd_r;
        end
      endcase
    end

    res_nxt.irq_out   = irq_nxt;
    res_nxt.mirroring = mirr_nxt;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cmd_r       <= '0;
      irq_en_r    <= 1'b0;
      cnt_r       <= '0;
      irq_r       <= 1'b0;
      mirr_r      <= '0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        cmd_r    <= cmd_nxt;
        irq_en_r <= irq_en_nxt;
        cnt_r    <= cnt_nxt;
        irq_r    <= irq_nxt;
        mirr_r   <= mirr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_item_r <= res_nxt;
    end
  end

endmodule
